### sv/sgfa_pkg.sv
// sgfa_pkg: shared types, constants and the seed table for the softened gravity
// force accumulator. no dependencies.
package sgfa_pkg;

  localparam int CoordW = 48;
  localparam int MagW   = 49;
  localparam int R2W    = 98;
  localparam int MulW   = 34;
  localparam int ProdW  = 2 * MulW;
  localparam int PW     = 81;
  localparam int QW     = 113;
  localparam int ShW    = QW + 32;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [47:0] SOFTENING_SQ_RESET  = 48'd429497;
  localparam logic [31:0] PARTICLE_MASS_RESET = 32'd4294967;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
    coord_t source_x;
    coord_t source_y;
    coord_t source_z;
    logic   first_pair;
    logic   last_pair;
  } in_t;

  typedef struct packed {
    coord_t accel_x;
    coord_t accel_y;
    coord_t accel_z;
    logic   overflow;
  } out_t;

  // one queued request: separation magnitudes and signs plus flags
  typedef struct packed {
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
    logic [MagW-1:0] mag_z;
    logic            neg_x;
    logic            neg_y;
    logic            neg_z;
    logic            first_pair;
    logic            last_pair;
  } pair_t;

  typedef enum logic {
    CFG_SOFTENING_SQ  = 1'b0,
    CFG_PARTICLE_MASS = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_NORM,
    ST_NEWTON,
    ST_CUBE,
    ST_FORCE,
    ST_SHIFT,
    ST_ADD,
    ST_EMIT
  } state_t;

  // inverse square root seed, Q0.16, indexed by top four mantissa bits
  function automatic logic [15:0] seed(input logic [3:0] idx);
    logic [15:0] v;
    unique case (idx)
      4'd0, 4'd1, 4'd2, 4'd3: v = 16'd65535;
      4'd4:  v = 16'd61788;
      4'd5:  v = 16'd55889;
      4'd6:  v = 16'd51411;
      4'd7:  v = 16'd47861;
      4'd8:  v = 16'd44957;
      4'd9:  v = 16'd42525;
      4'd10: v = 16'd40450;
      4'd11: v = 16'd38651;
      4'd12: v = 16'd37073;
      4'd13: v = 16'd35673;
      4'd14: v = 16'd34421;
      4'd15: v = 16'd33292;
      default: v = 16'd65535;
    endcase
    return v;
  endfunction

endpackage

### sv/sgfa_front.sv
// sgfa_front: accepts requests, forms separation magnitudes and signs and
// queues them for the back end. depends on sgfa_pkg.
module sgfa_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sgfa_pkg::in_t    in_data,
  input  logic             pop,
  output logic             item_valid,
  output sgfa_pkg::pair_t  item
);

  sgfa_pkg::pair_t                 queue [sgfa_pkg::QDepth];
  logic [sgfa_pkg::QPtrW-1:0]      wr_ptr;
  logic [sgfa_pkg::QPtrW-1:0]      rd_ptr;
  logic [sgfa_pkg::QPtrW:0]        count;
  logic                            push;
  logic                            do_pop;
  sgfa_pkg::pair_t                 entry;
  logic signed [sgfa_pkg::MagW-1:0] dx, dy, dz;

  assign dx = sgfa_pkg::MagW'(in_data.target_x) - sgfa_pkg::MagW'(in_data.source_x);
  assign dy = sgfa_pkg::MagW'(in_data.target_y) - sgfa_pkg::MagW'(in_data.source_y);
  assign dz = sgfa_pkg::MagW'(in_data.target_z) - sgfa_pkg::MagW'(in_data.source_z);

  always_comb begin
    entry.neg_x      = dx[sgfa_pkg::MagW-1];
    entry.neg_y      = dy[sgfa_pkg::MagW-1];
    entry.neg_z      = dz[sgfa_pkg::MagW-1];
    entry.mag_x      = entry.neg_x ? -dx : dx;
    entry.mag_y      = entry.neg_y ? -dy : dy;
    entry.mag_z      = entry.neg_z ? -dz : dz;
    entry.first_pair = in_data.first_pair;
    entry.last_pair  = in_data.last_pair;
  end

  assign in_stall   = (count == (sgfa_pkg::QPtrW+1)'(sgfa_pkg::QDepth));
  assign push       = in_valid && !in_stall;
  assign item_valid = (count != '0);
  assign item       = queue[rd_ptr];
  assign do_pop     = pop && item_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/sgfa_back.sv
// sgfa_back: sequencer around one shared multiplier that computes r2, the
// seeded newton inverse square root and the three saturating accumulations.
// depends on sgfa_pkg.
module sgfa_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  sgfa_pkg::pair_t  item,
  output logic             pop,
  input  logic [47:0]      softening_sq,
  input  logic [31:0]      particle_mass,
  output logic             out_valid,
  input  logic             out_stall,
  output sgfa_pkg::out_t   out_data
);

  sgfa_pkg::state_t state, state_next;
  sgfa_pkg::pair_t  cur;
  logic [1:0]  comp;
  logic [2:0]  part;
  logic [1:0]  step;
  logic [5:0]  shift_cnt;
  logic [sgfa_pkg::R2W-1:0] r2;
  logic [31:0] m, y, y2, w;
  logic [33:0] f;
  logic [sgfa_pkg::PW-1:0] p;
  logic [sgfa_pkg::QW-1:0] q;
  logic [48:0] c;
  logic signed [47:0] sum_x, sum_y, sum_z;
  logic saturated;
  logic out_load;

  logic [sgfa_pkg::MulW-1:0]  mul_a, mul_b;
  logic [sgfa_pkg::ProdW-1:0] prod;
  logic [48:0] mag_sel;
  logic        neg_sel;
  logic signed [47:0] acc_sel;
  logic [sgfa_pkg::R2W-1:0] sq_add;
  logic [33:0] t_val, f_calc, yq;
  logic [5:0]  h;
  logic [7:0]  h3;
  logic [sgfa_pkg::ShW-1:0] q_wide, shifted;
  logic signed [49:0] acc_sum;
  logic signed [47:0] acc_new;
  logic        acc_sat;

  always_comb begin
    unique case (comp)
      2'd0: begin mag_sel = cur.mag_x; neg_sel = cur.neg_x; acc_sel = sum_x; end
      2'd1: begin mag_sel = cur.mag_y; neg_sel = cur.neg_y; acc_sel = sum_y; end
      default: begin mag_sel = cur.mag_z; neg_sel = cur.neg_z; acc_sel = sum_z; end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      sgfa_pkg::ST_SQUARE: begin
        mul_a = (part == 3'd2) ? 34'(mag_sel[48:32]) : 34'(mag_sel[31:0]);
        mul_b = (part == 3'd0) ? 34'(mag_sel[31:0]) : 34'(mag_sel[48:32]);
      end
      sgfa_pkg::ST_NEWTON: begin
        mul_a = (part == 3'd1) ? 34'(m) : 34'(y);
        mul_b = (part == 3'd0) ? 34'(y) : ((part == 3'd1) ? 34'(y2) : f);
      end
      sgfa_pkg::ST_CUBE: begin
        mul_a = (part == 3'd0) ? 34'(y) : 34'(y2);
        mul_b = 34'(y);
      end
      sgfa_pkg::ST_FORCE: begin
        unique case (part)
          3'd0: begin mul_a = 34'(particle_mass); mul_b = 34'(mag_sel[31:0]); end
          3'd1: begin mul_a = 34'(particle_mass); mul_b = 34'(mag_sel[48:32]); end
          3'd2: begin mul_a = 34'(p[31:0]); mul_b = 34'(w); end
          3'd3: begin mul_a = 34'(p[63:32]); mul_b = 34'(w); end
          default: begin mul_a = 34'(p[80:64]); mul_b = 34'(w); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = sgfa_pkg::ProdW'(mul_a) * sgfa_pkg::ProdW'(mul_b);

  always_comb begin
    unique case (part)
      3'd0:    sq_add = sgfa_pkg::R2W'(prod);
      3'd1:    sq_add = sgfa_pkg::R2W'(prod) << 33;
      default: sq_add = sgfa_pkg::R2W'(prod) << 64;
    endcase
  end

  assign t_val  = prod[63:30];
  assign f_calc = (t_val >= 34'h3_0000_0000) ? '0 : (34'h3_0000_0000 - t_val);
  assign yq     = prod[66:33];

  // scale by 2^(32-3h) as a left or right shift
  assign h       = 6'd48 - shift_cnt;
  assign h3      = 8'(h) * 8'd3;
  assign q_wide  = sgfa_pkg::ShW'(q);
  assign shifted = (h3 <= 8'd32) ? (q_wide << (8'd32 - h3)) : (q_wide >> (h3 - 8'd32));

  always_comb begin
    acc_sum = neg_sel ? (50'(acc_sel) + $signed({1'b0, c}))
                      : (50'(acc_sel) - $signed({1'b0, c}));
    acc_sat = 1'b0;
    acc_new = acc_sum[47:0];
    if (acc_sum > 50'sh0_7FFF_FFFF_FFFF) begin
      acc_new = 48'sh7FFF_FFFF_FFFF;
      acc_sat = 1'b1;
    end else if (acc_sum < -50'sh0_8000_0000_0000) begin
      acc_new = 48'sh8000_0000_0000;
      acc_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      sgfa_pkg::ST_IDLE: begin
        if (item_valid) begin
          pop        = 1'b1;
          state_next = sgfa_pkg::ST_SQUARE;
        end
      end
      sgfa_pkg::ST_SQUARE: begin
        if (comp == 2'd2 && part == 3'd2) state_next = sgfa_pkg::ST_NORM;
      end
      sgfa_pkg::ST_NORM: begin
        if (r2 == '0) state_next = sgfa_pkg::ST_EMIT;
        else if (r2[97:96] != 2'b00) state_next = sgfa_pkg::ST_NEWTON;
      end
      sgfa_pkg::ST_NEWTON: begin
        if (step == 2'd3 && part == 3'd2) state_next = sgfa_pkg::ST_CUBE;
      end
      sgfa_pkg::ST_CUBE: begin
        if (part == 3'd1) state_next = sgfa_pkg::ST_FORCE;
      end
      sgfa_pkg::ST_FORCE: begin
        if (part == 3'd4) state_next = sgfa_pkg::ST_SHIFT;
      end
      sgfa_pkg::ST_SHIFT: state_next = sgfa_pkg::ST_ADD;
      sgfa_pkg::ST_ADD: begin
        state_next = (comp == 2'd2) ? sgfa_pkg::ST_EMIT : sgfa_pkg::ST_FORCE;
      end
      sgfa_pkg::ST_EMIT: begin
        if (!cur.last_pair) begin
          state_next = sgfa_pkg::ST_IDLE;
        end else if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = sgfa_pkg::ST_IDLE;
        end
      end
      default: state_next = sgfa_pkg::ST_IDLE;
    endcase
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x     <= '0;
      sum_y     <= '0;
      sum_z     <= '0;
      saturated <= 1'b0;
    end else if (state == sgfa_pkg::ST_IDLE && item_valid && item.first_pair) begin
      sum_x     <= '0;
      sum_y     <= '0;
      sum_z     <= '0;
      saturated <= 1'b0;
    end else if (state == sgfa_pkg::ST_ADD) begin
      unique case (comp)
        2'd0:    sum_x <= acc_new;
        2'd1:    sum_y <= acc_new;
        default: sum_z <= acc_new;
      endcase
      if (acc_sat) saturated <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      sgfa_pkg::ST_IDLE: begin
        if (item_valid) begin
          cur       <= item;
          r2        <= {18'b0, softening_sq, 32'b0};
          comp      <= 2'd0;
          part      <= 3'd0;
          shift_cnt <= 6'd0;
        end
      end
      sgfa_pkg::ST_SQUARE: begin
        r2 <= r2 + sq_add;
        if (part == 3'd2) begin
          part <= 3'd0;
          comp <= comp + 2'd1;
        end else begin
          part <= part + 3'd1;
        end
      end
      sgfa_pkg::ST_NORM: begin
        if (r2 != '0) begin
          if (r2[97:90] == 8'd0) begin
            r2        <= r2 << 8;
            shift_cnt <= shift_cnt + 6'd4;
          end else if (r2[97:96] == 2'b00) begin
            r2        <= r2 << 2;
            shift_cnt <= shift_cnt + 6'd1;
          end else begin
            m    <= r2[97:66];
            y    <= {sgfa_pkg::seed(r2[97:94]), 16'b0};
            part <= 3'd0;
            step <= 2'd0;
            comp <= 2'd0;
          end
        end
      end
      sgfa_pkg::ST_NEWTON: begin
        unique case (part)
          3'd0: begin
            y2   <= prod[63:32];
            part <= 3'd1;
          end
          3'd1: begin
            f    <= f_calc;
            part <= 3'd2;
          end
          default: begin
            y    <= (yq[33:32] != 2'b00) ? 32'hFFFF_FFFF : yq[31:0];
            step <= step + 2'd1;
            part <= 3'd0;
          end
        endcase
      end
      sgfa_pkg::ST_CUBE: begin
        if (part == 3'd0) begin
          y2   <= prod[63:32];
          part <= 3'd1;
        end else begin
          w    <= prod[63:32];
          part <= 3'd0;
        end
      end
      sgfa_pkg::ST_FORCE: begin
        unique case (part)
          3'd0: p <= sgfa_pkg::PW'(prod);
          3'd1: p <= p + (sgfa_pkg::PW'(prod) << 32);
          3'd2: q <= sgfa_pkg::QW'(prod);
          3'd3: q <= q + (sgfa_pkg::QW'(prod) << 32);
          default: q <= q + (sgfa_pkg::QW'(prod) << 64);
        endcase
        part <= (part == 3'd4) ? 3'd0 : part + 3'd1;
      end
      sgfa_pkg::ST_SHIFT: begin
        // magnitudes past 2^48 saturate the sum anyway
        c <= (shifted > sgfa_pkg::ShW'(49'h1_0000_0000_0000)) ? 49'h1_0000_0000_0000
                                                                 : shifted[48:0];
      end
      sgfa_pkg::ST_ADD: begin
        comp <= comp + 2'd1;
      end
      default: begin
        part <= part;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.accel_x  <= sum_x;
      out_data.accel_y  <= sum_y;
      out_data.accel_z  <= sum_z;
      out_data.overflow <= saturated;
    end
  end

endmodule

### sv/softened_gravity_force_accumulator_unit.sv
// softened_gravity_force_accumulator_unit: top level, configuration registers
// and the front/back split. depends on sgfa_pkg, sgfa_front and sgfa_back.
//
// One request carries a target and a source position in signed Q16.32. The
// front end forms the separation and queues it (four deep), so requests keep
// arriving while the back end works. The back end squares and sums the
// separation plus softening_sq, normalizes r2 two bits at a time (eight when
// possible), seeds an inverse square root from a 16 entry table, refines it
// with four newton steps and cubes it, then adds -particle_mass*d*r2^-1.5 to
// each saturating accumulator. first_pair clears the sums before the add,
// last_pair emits them with the overflow flag after it. Everything runs
// through one shared 34x34 multiplier, one product per cycle. A request
// holds the back end while it is popped, squared into r2, normalized,
// refined by newton, cubed, applied to each component and emitted; one with
// zero r2 skips straight to emit. A last_pair emit waits for as long as a
// result already in the output register is stalled. The user must write
// configuration only while no request is in flight; the block does not enforce it.
module softened_gravity_force_accumulator_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sgfa_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sgfa_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [47:0]     cfg_data
);

  logic [47:0]     softening_sq;
  logic [31:0]     particle_mass;
  logic            item_valid;
  logic            pop;
  sgfa_pkg::pair_t item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      softening_sq  <= sgfa_pkg::SOFTENING_SQ_RESET;
      particle_mass <= sgfa_pkg::PARTICLE_MASS_RESET;
    end else if (cfg_we) begin
      unique case (sgfa_pkg::cfg_idx_t'(cfg_index))
        sgfa_pkg::CFG_SOFTENING_SQ:  softening_sq  <= cfg_data;
        sgfa_pkg::CFG_PARTICLE_MASS: particle_mass <= cfg_data[31:0];
        default:                     softening_sq  <= softening_sq;
      endcase
    end
  end

  // front end: request intake and separation queue
  sgfa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item)
  );

  // back end: force sequencer and accumulators
  sgfa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .pop           (pop),
    .softening_sq  (softening_sq),
    .particle_mass (particle_mass),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
